// ===== hw/rtl/cps_pkg.sv =====
// Shared types, constants and tables for the cart-pole dynamics step block.
package cps_pkg;

  localparam int VALUE_BITS        = 24;
  localparam int FRACTION_BITS     = 16;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int GUARD_BITS        = 4;
  localparam int ITER_BITS         = $clog2(CORDIC_ITERATIONS);
  localparam int ANGLE_BITS        = VALUE_BITS + GUARD_BITS;
  localparam int VEC_BITS          = VALUE_BITS + 1;
  localparam int QUO_BITS          = VALUE_BITS + FRACTION_BITS;
  localparam int CFG_INDEX_BITS    = 3;
  localparam int CFG_DATA_BITS     = 23;

  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic signed [ANGLE_BITS-1:0] ang_t;
  typedef logic signed [VEC_BITS-1:0]   vec_t;

  typedef struct packed {
    logic action;
    logic clear_first;
  } cmd_t;

  typedef struct packed {
    val_t cart_position;
    val_t cart_velocity;
    val_t pole_angle;
    val_t pole_rate;
    logic in_bounds;
  } res_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PUSH_FORCE     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIME_STEP      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POSITION_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_LIMIT    = 3'd3;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB
  } alu_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TRIG, ST_SC, ST_RR, ST_C20, ST_MS, ST_ADDF, ST_TEMP,
    ST_NS, ST_NC, ST_NUM, ST_CC, ST_C11, ST_D43, ST_DEN, ST_DSTART,
    ST_DIV, ST_T22, ST_TC, ST_XACC, ST_PM, ST_PA, ST_VM, ST_VA,
    ST_AM, ST_AA, ST_RM, ST_RA, ST_DONE
  } seq_state_t;

  typedef enum logic [2:0] {
    CD_IDLE, CD_RED, CD_WRAP, CD_FOLD, CD_ITER, CD_FIN, CD_DONE
  } cordic_state_t;

  typedef enum logic [1:0] {
    DV_IDLE, DV_RUN, DV_FIN, DV_DONE
  } div_state_t;

  // Q8.16 constants
  localparam val_t C_1_20  = 24'sd3277;
  localparam val_t C_10_11 = 24'sd59578;
  localparam val_t C_49_5  = 24'sd642253;
  localparam val_t C_1_2   = 24'sd32768;
  localparam val_t C_4_3   = 24'sd87381;
  localparam val_t C_1_11  = 24'sd5958;
  localparam val_t C_1_22  = 24'sd2979;
  localparam val_t VMAX    = 24'sh7FFFFF;
  localparam val_t VMIN    = 24'sh800000;

  // angles with 20 fraction bits
  localparam ang_t PI_W      = 28'sd3294199;
  localparam ang_t TWO_PI_W  = 28'sd6588397;
  localparam ang_t HALF_PI_W = 28'sd1647099;
  localparam vec_t GAIN_W    = 25'sd636751;

  function automatic ang_t atan_pow2(input logic [ITER_BITS-1:0] i);
    ang_t r;
    case (i)
      4'd0:    r = 28'sd823550;
      4'd1:    r = 28'sd486170;
      4'd2:    r = 28'sd256879;
      4'd3:    r = 28'sd130396;
      4'd4:    r = 28'sd65451;
      4'd5:    r = 28'sd32757;
      4'd6:    r = 28'sd16383;
      4'd7:    r = 28'sd8192;
      4'd8:    r = 28'sd4096;
      4'd9:    r = 28'sd2048;
      4'd10:   r = 28'sd1024;
      4'd11:   r = 28'sd512;
      4'd12:   r = 28'sd256;
      4'd13:   r = 28'sd128;
      4'd14:   r = 28'sd64;
      default: r = 28'sd32;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/cps_alu.sv =====
// Shared fixed-point unit: rounded saturating multiply, saturating add and subtract.
module cps_alu (
  input  cps_pkg::alu_op_t op,
  input  cps_pkg::val_t    a,
  input  cps_pkg::val_t    b,
  output cps_pkg::val_t    y
);
  import cps_pkg::*;

  localparam int PW = 2 * VALUE_BITS;
  localparam int RW = PW + 1 - FRACTION_BITS;
  localparam logic [RW-1:0] CAP = RW'(1) << (VALUE_BITS - 1);

  logic [VALUE_BITS-1:0]        ma, mb;
  logic [PW-1:0]                prod;
  logic [PW:0]                  psum;
  logic [RW-1:0]                rnd;
  logic [VALUE_BITS-1:0]        mag;
  logic signed [VALUE_BITS+1:0] s;

  always_comb begin
    ma   = a[VALUE_BITS-1] ? unsigned'(-a) : unsigned'(a);
    mb   = b[VALUE_BITS-1] ? unsigned'(-b) : unsigned'(b);
    prod = PW'(ma) * PW'(mb);
    psum = {1'b0, prod} + ((PW + 1)'(1) << (FRACTION_BITS - 1));
    rnd  = psum[PW:FRACTION_BITS];
    mag  = (rnd > CAP) ? CAP[VALUE_BITS-1:0] : rnd[VALUE_BITS-1:0];
    case (op)
      OP_MUL: begin
        if (a[VALUE_BITS-1] ^ b[VALUE_BITS-1]) begin
          s = -$signed({2'b00, mag});
        end else begin
          s = $signed({2'b00, mag});
        end
      end
      OP_ADD:  s = (VALUE_BITS + 2)'(a) + (VALUE_BITS + 2)'(b);
      OP_SUB:  s = (VALUE_BITS + 2)'(a) - (VALUE_BITS + 2)'(b);
      default: s = '0;
    endcase
    if (s > (VALUE_BITS + 2)'(VMAX)) begin
      y = VMAX;
    end else if (s < (VALUE_BITS + 2)'(VMIN)) begin
      y = VMIN;
    end else begin
      y = s[VALUE_BITS-1:0];
    end
  end

endmodule

// ===== hw/rtl/cps_div.sv =====
// Restoring divider, one quotient bit per cycle, rounded and saturated Q8.16 quotient.
module cps_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cps_pkg::val_t n,
  input  cps_pkg::val_t d,
  output logic          done,
  output cps_pkg::val_t q
);
  import cps_pkg::*;

  localparam int CNT_BITS = $clog2(QUO_BITS);
  localparam logic [QUO_BITS-1:0] CAP = QUO_BITS'(1) << (VALUE_BITS - 1);

  div_state_t                state, state_next;
  logic [CNT_BITS-1:0]       cnt;
  logic [VALUE_BITS-1:0]     rem;
  logic [VALUE_BITS:0]       rem_sh;
  logic [QUO_BITS-1:0]       dvd, quo, quo_rnd;
  logic [VALUE_BITS-1:0]     dsr;
  logic                      neg;
  logic [VALUE_BITS-1:0]     mag;

  always_comb begin
    state_next = state;
    case (state)
      DV_IDLE: if (start) state_next = (d <= 0) ? DV_DONE : DV_RUN;
      DV_RUN:  if (cnt == CNT_BITS'(QUO_BITS - 1)) state_next = DV_FIN;
      DV_FIN:  state_next = DV_DONE;
      DV_DONE: state_next = DV_IDLE;
      default: state_next = DV_IDLE;
    endcase
  end

  always_comb begin
    done    = (state == DV_DONE);
    rem_sh  = {rem, dvd[QUO_BITS-1]};
    quo_rnd = quo + QUO_BITS'(({rem, 1'b0} >= {1'b0, dsr}) ? 1 : 0);
    if (quo > CAP || quo_rnd > CAP) begin
      mag = CAP[VALUE_BITS-1:0];
    end else begin
      mag = quo_rnd[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        neg <= n[VALUE_BITS-1];
        cnt <= '0;
        rem <= '0;
        quo <= '0;
        dsr <= unsigned'(d);
        dvd <= {(n[VALUE_BITS-1] ? unsigned'(-n) : unsigned'(n)), FRACTION_BITS'(0)};
        q   <= n[VALUE_BITS-1] ? VMIN : VMAX;
      end
      DV_RUN: begin
        if (rem_sh >= {1'b0, dsr}) begin
          rem <= VALUE_BITS'(rem_sh - {1'b0, dsr});
          quo <= {quo[QUO_BITS-2:0], 1'b1};
        end else begin
          rem <= rem_sh[VALUE_BITS-1:0];
          quo <= {quo[QUO_BITS-2:0], 1'b0};
        end
        dvd <= {dvd[QUO_BITS-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      DV_FIN: begin
        if (neg) begin
          q <= val_t'(-$signed({1'b0, mag}));
        end else if (mag[VALUE_BITS-1]) begin
          q <= VMAX;
        end else begin
          q <= $signed(mag);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/cps_cordic.sv =====
// Iterative rotation CORDIC with modulo-2pi reduction, giving sin and cos of the pole angle.
module cps_cordic (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cps_pkg::val_t angle,
  output logic          done,
  output cps_pkg::val_t sin_v,
  output cps_pkg::val_t cos_v
);
  import cps_pkg::*;

  cordic_state_t         state, state_next;
  ang_t                  z;
  vec_t                  x, y, xr, yr;
  logic                  flip;
  logic [ITER_BITS-1:0]  i;

  always_comb begin
    state_next = state;
    case (state)
      CD_IDLE: if (start) state_next = CD_RED;
      CD_RED: begin
        if (!(z[ANGLE_BITS-1] ? (z <= -TWO_PI_W) : (z >= TWO_PI_W))) state_next = CD_WRAP;
      end
      CD_WRAP: state_next = CD_FOLD;
      CD_FOLD: state_next = CD_ITER;
      CD_ITER: if (i == ITER_BITS'(CORDIC_ITERATIONS - 1)) state_next = CD_FIN;
      CD_FIN:  state_next = CD_DONE;
      CD_DONE: state_next = CD_IDLE;
      default: state_next = CD_IDLE;
    endcase
  end

  always_comb begin
    done = (state == CD_DONE);
    xr   = (x + vec_t'(1 << (GUARD_BITS - 1))) >>> GUARD_BITS;
    yr   = (y + vec_t'(1 << (GUARD_BITS - 1))) >>> GUARD_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      CD_IDLE: z <= ang_t'(angle) <<< GUARD_BITS;
      CD_RED: begin
        if (!z[ANGLE_BITS-1] && z >= TWO_PI_W) begin
          z <= z - TWO_PI_W;
        end else if (z[ANGLE_BITS-1] && z <= -TWO_PI_W) begin
          z <= z + TWO_PI_W;
        end
      end
      CD_WRAP: begin
        if (z > PI_W) begin
          z <= z - TWO_PI_W;
        end else if (z < -PI_W) begin
          z <= z + TWO_PI_W;
        end
      end
      CD_FOLD: begin
        flip <= (z > HALF_PI_W) || (z < -HALF_PI_W);
        if (z > HALF_PI_W) begin
          z <= z - PI_W;
        end else if (z < -HALF_PI_W) begin
          z <= z + PI_W;
        end
        x <= GAIN_W;
        y <= '0;
        i <= '0;
      end
      CD_ITER: begin
        if (!z[ANGLE_BITS-1]) begin
          x <= x - (y >>> i);
          y <= y + (x >>> i);
          z <= z - atan_pow2(i);
        end else begin
          x <= x + (y >>> i);
          y <= y - (x >>> i);
          z <= z + atan_pow2(i);
        end
        i <= i + 1'b1;
      end
      CD_FIN: begin
        cos_v <= val_t'(flip ? -xr : xr);
        sin_v <= val_t'(flip ? -yr : yr);
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/cart_pole_dynamics_step.sv =====
// Top level: cart-pole Euler step sequencer around one shared arithmetic unit.
// Each command beat runs one Euler step of the cart-pole state and returns one result beat.
// The step is 23 passes through the shared multiply/add unit, plus the CORDIC (one
// subtraction or addition of 2*pi per cycle for range reduction, up to 20 for the largest
// angles, then 16 rotation steps), plus a divider that produces one quotient bit per cycle
// for its 40 quotient bits. The block takes no new command until the step is done. A
// finished result waits in the output register while the next command is accepted.
// Configuration writes are always ready. Write them only while no step is in flight.
module cart_pole_dynamics_step (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cmd_valid,
  output logic                                  cmd_stall,
  input  cps_pkg::cmd_t                         cmd,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output cps_pkg::res_t                         res,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [cps_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import cps_pkg::*;

  seq_state_t   state, state_next;
  logic [22:0]  push_force;
  logic [15:0]  time_step;
  logic [22:0]  position_limit;
  logic [17:0]  angle_limit;
  val_t         pos, vel, ang, rate;
  val_t         s_v, c_v, t1, temp, num, den, th, xacc;
  logic         action;
  val_t         fmag, push_val, tau;
  alu_op_t      op;
  val_t         opa, opb, alu_y;
  logic         cd_start, cd_done, dv_start, dv_done;
  val_t         cd_sin, cd_cos, dv_q;
  logic         out_free;
  logic [VALUE_BITS-1:0] abs_pos, abs_ang;

  cps_alu u_alu (.op(op), .a(opa), .b(opb), .y(alu_y));

  cps_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cd_start), .angle(ang),
    .done(cd_done), .sin_v(cd_sin), .cos_v(cd_cos)
  );

  cps_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .n(num), .d(den),
    .done(dv_done), .q(dv_q)
  );

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != ST_IDLE);
  assign out_free  = !res_valid || !res_stall;

  always_comb begin
    fmag     = val_t'({1'b0, push_force});
    push_val = action ? fmag : -fmag;
    tau      = val_t'({8'b0, time_step});
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (cmd_valid) state_next = ST_TRIG;
      ST_TRIG:   state_next = ST_SC;
      ST_SC:     if (cd_done) state_next = ST_RR;
      ST_RR:     state_next = ST_C20;
      ST_C20:    state_next = ST_MS;
      ST_MS:     state_next = ST_ADDF;
      ST_ADDF:   state_next = ST_TEMP;
      ST_TEMP:   state_next = ST_NS;
      ST_NS:     state_next = ST_NC;
      ST_NC:     state_next = ST_NUM;
      ST_NUM:    state_next = ST_CC;
      ST_CC:     state_next = ST_C11;
      ST_C11:    state_next = ST_D43;
      ST_D43:    state_next = ST_DEN;
      ST_DEN:    state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DIV;
      ST_DIV:    if (dv_done) state_next = ST_T22;
      ST_T22:    state_next = ST_TC;
      ST_TC:     state_next = ST_XACC;
      ST_XACC:   state_next = ST_PM;
      ST_PM:     state_next = ST_PA;
      ST_PA:     state_next = ST_VM;
      ST_VM:     state_next = ST_VA;
      ST_VA:     state_next = ST_AM;
      ST_AM:     state_next = ST_AA;
      ST_AA:     state_next = ST_RM;
      ST_RM:     state_next = ST_RA;
      ST_RA:     state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cd_start = (state == ST_TRIG);
    dv_start = (state == ST_DSTART);
    op  = OP_MUL;
    opa = '0;
    opb = '0;
    case (state)
      ST_RR:   begin opa = rate;   opb = rate;    end
      ST_C20:  begin opa = C_1_20; opb = t1;      end
      ST_MS:   begin opa = t1;     opb = s_v;     end
      ST_ADDF: begin op = OP_ADD;  opa = push_val; opb = t1; end
      ST_TEMP: begin opa = t1;     opb = C_10_11; end
      ST_NS:   begin opa = C_49_5; opb = s_v;     end
      ST_NC:   begin opa = c_v;    opb = temp;    end
      ST_NUM:  begin op = OP_SUB;  opa = num;   opb = t1; end
      ST_CC:   begin opa = c_v;    opb = c_v;     end
      ST_C11:  begin opa = C_1_11; opb = t1;      end
      ST_D43:  begin op = OP_SUB;  opa = C_4_3; opb = t1; end
      ST_DEN:  begin opa = C_1_2;  opb = t1;      end
      ST_T22:  begin opa = C_1_22; opb = th;      end
      ST_TC:   begin opa = t1;     opb = c_v;     end
      ST_XACC: begin op = OP_SUB;  opa = temp;  opb = t1; end
      ST_PM:   begin opa = tau;    opb = vel;     end
      ST_PA:   begin op = OP_ADD;  opa = pos;   opb = t1; end
      ST_VM:   begin opa = tau;    opb = xacc;    end
      ST_VA:   begin op = OP_ADD;  opa = vel;   opb = t1; end
      ST_AM:   begin opa = tau;    opb = rate;    end
      ST_AA:   begin op = OP_ADD;  opa = ang;   opb = t1; end
      ST_RM:   begin opa = tau;    opb = th;      end
      ST_RA:   begin op = OP_ADD;  opa = rate;  opb = t1; end
      default: ;
    endcase
  end

  always_comb begin
    abs_pos = pos[VALUE_BITS-1] ? unsigned'(-pos) : unsigned'(pos);
    abs_ang = ang[VALUE_BITS-1] ? unsigned'(-ang) : unsigned'(ang);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      res_valid      <= 1'b0;
      push_force     <= 23'd655360;
      time_step      <= 16'd1311;
      position_limit <= 23'd262144;
      angle_limit    <= 18'd82355;
      pos            <= '0;
      vel            <= '0;
      ang            <= '0;
      rate           <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PUSH_FORCE:     push_force     <= cfg_data[22:0];
          REG_TIME_STEP:      time_step      <= cfg_data[15:0];
          REG_POSITION_LIMIT: position_limit <= cfg_data[22:0];
          REG_ANGLE_LIMIT:    angle_limit    <= cfg_data[17:0];
          default: ;
        endcase
      end
      if (state == ST_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid && cmd.clear_first) begin
            pos  <= '0;
            vel  <= '0;
            ang  <= '0;
            rate <= '0;
          end
        end
        ST_PA:   pos  <= alu_y;
        ST_VA:   vel  <= alu_y;
        ST_AA:   ang  <= alu_y;
        ST_RA:   rate <= alu_y;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: action <= cmd.action;
      ST_SC: begin
        s_v <= cd_sin;
        c_v <= cd_cos;
      end
      ST_RR, ST_C20, ST_MS, ST_ADDF, ST_NC, ST_CC, ST_C11, ST_D43, ST_T22, ST_TC,
      ST_PM, ST_VM, ST_AM, ST_RM: t1 <= alu_y;
      ST_TEMP: temp <= alu_y;
      ST_NS, ST_NUM: num <= alu_y;
      ST_DEN:  den  <= alu_y;
      ST_DIV:  th   <= dv_q;
      ST_XACC: xacc <= alu_y;
      ST_DONE: begin
        if (out_free) begin
          res.cart_position <= pos;
          res.cart_velocity <= vel;
          res.pole_angle    <= ang;
          res.pole_rate     <= rate;
          res.in_bounds     <= (abs_pos < {1'b0, position_limit}) &&
                               (abs_ang < VALUE_BITS'(angle_limit));
        end
      end
      default: ;
    endcase
  end

endmodule
